[sv/rmt_pkg.sv]
// ----------------------------------------------------------------------------
// rmt_pkg: shared constants for the running median tracker
// Field widths of the sample and result transfers and the default store size.
// ----------------------------------------------------------------------------
package rmt_pkg;

  // Width of one stored sample.
  localparam int SAMPLE_W = 32;

  // Twice the median, one bit wider than a sample so a sum of two never overflows.
  localparam int MEDIAN_W = 33;

  // Width of the reported sample count.
  localparam int COUNT_OUT_W = 7;

  // Default number of cells in the sorted chain.
  localparam int DEFAULT_CAPACITY = 64;

endpackage

[sv/rmt_if.sv]
// ----------------------------------------------------------------------------
// rmt_sample_if / rmt_result_if: valid/ready channels of the median tracker
// Sample channel carries one signed sample; result channel carries the median.
// ----------------------------------------------------------------------------
interface rmt_sample_if
  import rmt_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmt_result_if
  import rmt_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic signed [MEDIAN_W-1:0] median_doubled;
  logic                       rejected;
  logic [COUNT_OUT_W-1:0]     stored_count;

  modport source (output valid, output median_doubled, output rejected,
                  output stored_count, input ready);
  modport sink (input valid, input median_doubled, input rejected,
                input stored_count, output ready);
endinterface

[sv/running_median_tracker.sv]
// ----------------------------------------------------------------------------
// running_median_tracker: running median over a sorted chain of cells
//
//   channel   | modport | payload                                  | role
//   ----------+---------+------------------------------------------+-----------
//   samples   | sink    | sample (32b signed)                      | new sample
//   medians   | source  | median_doubled (33b signed), rejected,   | one result
//             |         | stored_count (7b)                        | per sample
//
// Each sample passes through the insert into the cell chain on the transfer,
// the pick of the middle cells, and the add of them into the output
// register. A waiting result holds the final add, and no new sample is taken
// until it is done. Reset (rst, synchronous) empties the store and drops
// any pending result. Cell contents are not cleared; only the first count
// cells are ever read.
// ----------------------------------------------------------------------------
module running_median_tracker
  import rmt_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
)
(
  input  logic         clk,
  input  logic         rst,
  rmt_sample_if.sink   samples,
  rmt_result_if.source medians
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SELECT,
    ST_SUM
  } state_t;

  state_t                     state;
  logic [CNT_W-1:0]           count;
  logic                       rej;
  logic signed [MEDIAN_W-1:0] mid_lo;
  logic signed [MEDIAN_W-1:0] mid_hi;

  logic                       res_valid;
  logic signed [MEDIAN_W-1:0] res_median;
  logic                       res_rej;
  logic [COUNT_OUT_W-1:0]     res_count;

  logic                       accept;
  logic                       full;
  logic                       insert;
  logic                       keep_vec [CAPACITY];
  logic signed [SAMPLE_W-1:0] cell_val [CAPACITY];
  logic [CNT_W-1:0]           half;
  logic [CNT_W-1:0]           lo_idx;
  logic signed [SAMPLE_W-1:0] sel_lo;
  logic signed [SAMPLE_W-1:0] sel_hi;
  logic                       out_free;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  // Handshake on the sample side.
  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign full          = (count == CNT_W'(CAPACITY));
  assign insert        = accept && !full;

  // Chain of cells; the first cell sees a kept boundary on its left.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                       left_keep;
    logic signed [SAMPLE_W-1:0] left_value;
    if (i == 0) begin : g_first
      assign left_keep  = 1'b1;
      assign left_value = samples.sample;
    end else begin : g_rest
      assign left_keep  = keep_vec[i-1];
      assign left_value = cell_val[i-1];
    end
    rmt_cell u_cell (
      .clk        (clk),
      .insert     (insert),
      .occupied   (CNT_W'(i) < count),
      .new_sample (samples.sample),
      .left_keep  (left_keep),
      .left_value (left_value),
      .keep       (keep_vec[i]),
      .value      (cell_val[i])
    );
  end

  // Pick the middle cells: one cell doubled for an odd count, two for an even one.
  assign half   = count >> 1;
  assign lo_idx = count[0] ? half : half - CNT_W'(1);

  always_comb begin
    sel_lo = '0;
    sel_hi = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CNT_W'(i) == lo_idx) begin
        sel_lo = sel_lo | cell_val[i];
      end
      if (CNT_W'(i) == half) begin
        sel_hi = sel_hi | cell_val[i];
      end
    end
  end

  // Output register is free when empty or being drained this cycle.
  assign out_free  = !res_valid || medians.ready;
  assign count_ext = (CNT_W + COUNT_OUT_W)'(count);

  // Sequencer, count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // A new result takes priority over the drain of the old one.
      if (state == ST_SUM && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && medians.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rej   <= full;
            state <= ST_SELECT;
            if (!full) begin
              count <= count + CNT_W'(1);
            end
          end
        end
        ST_SELECT: begin
          mid_lo <= MEDIAN_W'(sel_lo);
          mid_hi <= MEDIAN_W'(sel_hi);
          state  <= ST_SUM;
        end
        ST_SUM: begin
          if (out_free) begin
            res_median <= mid_lo + mid_hi;
            res_rej    <= rej;
            res_count  <= count_ext[COUNT_OUT_W-1:0];
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign medians.valid          = res_valid;
  assign medians.median_doubled = res_median;
  assign medians.rejected       = res_rej;
  assign medians.stored_count   = res_count;

  // The store never holds more samples than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("sample count exceeds capacity");

  // A sample transfer always starts the middle-cell pick.
  a_accept_select: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SELECT)
    else $error("transfer did not start the median pick");

  // A rejected sample leaves the count unchanged.
  a_reject_count: assert property (@(posedge clk) disable iff (rst)
    (accept && full) |=> $stable(count))
    else $error("rejected sample changed the count");

  // The first two stored samples stay in ascending order.
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SELECT && count >= CNT_W'(2)) |-> cell_val[0] <= cell_val[1])
    else $error("cell chain out of order");

endmodule

[sv/rmt_cell.sv]
// ----------------------------------------------------------------------------
// rmt_cell: one cell of the sorted insertion chain
// Holds one sample. On an insert it keeps its value, takes the new sample, or
// takes its left neighbor's value, so the whole chain stays in ascending order.
// ----------------------------------------------------------------------------
module rmt_cell
  import rmt_pkg::*;
(
  input  logic                       clk,
  input  logic                       insert,
  input  logic                       occupied,
  input  logic signed [SAMPLE_W-1:0] new_sample,
  input  logic                       left_keep,
  input  logic signed [SAMPLE_W-1:0] left_value,
  output logic                       keep,
  output logic signed [SAMPLE_W-1:0] value
);

  // The cell stays put when it holds a sample not above the new one, so equal
  // samples end up ahead of the new sample.
  assign keep = occupied && (value <= new_sample);

  // First cell that does not stay takes the new sample; later ones shift right.
  always_ff @(posedge clk) begin
    if (insert && !keep) begin
      if (left_keep) begin
        value <= new_sample;
      end else begin
        value <= left_value;
      end
    end
  end

endmodule

[test/tb_running_median_tracker.sv]
// ----------------------------------------------------------------------------
// tb_running_median_tracker: self-checking bench for the running median tracker
// Drives signed samples and checks each median result against a sorted-list
// predictor. It starts with a table of edge cases, then runs random samples
// under several sender and receiver idle patterns, including one long
// receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_running_median_tracker;
  import rmt_pkg::*;

  localparam int CAPACITY      = DEFAULT_CAPACITY;
  localparam int RANDOM_ITEMS  = 430;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;

  // One result as the medians channel carries it.
  typedef struct packed {
    logic signed [MEDIAN_W-1:0] median_doubled;
    logic                       rejected;
    logic [COUNT_OUT_W-1:0]     stored_count;
  } median_result_t;

  // One row of the directed table; known rows carry a hand-written result.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       known;
    median_result_t             want;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [20] = '{
    '{32'sh8000_0000, 1'b1, '{33'sh1_0000_0000, 1'b0, 7'd1}},
    '{32'sh7FFF_FFFF, 1'b1, '{33'sh1_FFFF_FFFF, 1'b0, 7'd2}},
    '{32'sh7FFF_FFFF, 1'b1, '{33'sh0_FFFF_FFFE, 1'b0, 7'd3}},
    '{32'sh8000_0000, 1'b1, '{33'sh1_FFFF_FFFF, 1'b0, 7'd4}},
    '{32'sh0000_0000, 1'b1, '{33'sh0_0000_0000, 1'b0, 7'd5}},
    '{32'sh0000_0000, 1'b1, '{33'sh0_0000_0000, 1'b0, 7'd6}},
    '{32'shFFFF_FFFF, 1'b0, '0},
    '{32'sh0000_0001, 1'b0, '0},
    '{32'sh5555_5555, 1'b0, '0},
    '{32'shAAAA_AAAA, 1'b0, '0},
    '{32'sh7FFF_FFFE, 1'b0, '0},
    '{32'sh8000_0001, 1'b0, '0},
    '{32'sh0000_0001, 1'b0, '0},
    '{32'sh0000_0001, 1'b0, '0},
    '{32'shFFFF_FFFF, 1'b0, '0},
    '{32'sh0000_FFFF, 1'b0, '0},
    '{32'shFFFF_0000, 1'b0, '0},
    '{32'sh0000_0064, 1'b0, '0},
    '{32'shFFFF_FF9C, 1'b0, '0},
    '{32'sh0000_0064, 1'b0, '0}
  };

  logic clk;
  logic rst;

  rmt_sample_if sample_ch ();
  rmt_result_if median_ch ();

  running_median_tracker #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_ch),
    .medians (median_ch)
  );

  // Predictor state: every stored sample in ascending order.
  logic signed [SAMPLE_W-1:0] sorted_samples [$];
  median_result_t             pending_medians [$];

  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          mismatch_count;
  int unsigned cycle_count;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Insert a sample the way the block does and return twice the new median.
  function automatic median_result_t predict_median(logic signed [SAMPLE_W-1:0] s);
    median_result_t             r;
    int                         pos;
    int                         n;
    logic signed [MEDIAN_W-1:0] lo;
    logic signed [MEDIAN_W-1:0] hi;
    r.rejected = (sorted_samples.size() >= CAPACITY);
    if (!r.rejected) begin
      pos = 0;
      while (pos < sorted_samples.size() && sorted_samples[pos] <= s) pos++;
      sorted_samples.insert(pos, s);
    end
    n = sorted_samples.size();
    hi = sorted_samples[n / 2];
    lo = (n % 2 == 1) ? hi : sorted_samples[n / 2 - 1];
    r.median_doubled = lo + hi;
    r.stored_count   = n[COUNT_OUT_W-1:0];
    return r;
  endfunction

  // Offer one sample from a falling edge, with random gaps, until the transfer.
  task automatic transfer_sample(logic signed [SAMPLE_W-1:0] s, logic known,
                                 median_result_t want);
    median_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(negedge clk);
    end
    sample_ch.valid  <= 1'b1;
    sample_ch.sample <= s;
    do @(posedge clk); while (!sample_ch.ready);
    predicted = predict_median(s);
    pending_medians.push_back(known ? want : predicted);
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    median_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        median_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        median_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    median_result_t exp_r;
    if (!rst && median_ch.valid && median_ch.ready) begin
      if (pending_medians.size() == 0) begin
        $error("unexpected result: median_doubled %0d, rejected %0d, stored_count %0d",
               median_ch.median_doubled, median_ch.rejected, median_ch.stored_count);
        mismatch_count++;
      end else begin
        exp_r = pending_medians.pop_front();
        if (median_ch.median_doubled !== exp_r.median_doubled) begin
          $error("median_doubled: expected %0d, got %0d",
                 exp_r.median_doubled, median_ch.median_doubled);
          mismatch_count++;
        end
        if (median_ch.rejected !== exp_r.rejected) begin
          $error("rejected: expected %0d, got %0d", exp_r.rejected, median_ch.rejected);
          mismatch_count++;
        end
        if (median_ch.stored_count !== exp_r.stored_count) begin
          $error("stored_count: expected %0d, got %0d",
                 exp_r.stored_count, median_ch.stored_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("running_median_tracker: mismatch");
      $finish;
    end
  end

  // Stimulus: directed table, then random samples across idle phases.
  initial begin
    logic signed [SAMPLE_W-1:0] s;
    logic signed [SAMPLE_W-1:0] recent;
    int                         k;
    rst              = 1'b1;
    sample_ch.valid  = 1'b0;
    sample_ch.sample = '0;
    hold_req         = 1'b0;
    mismatch_count   = 0;
    cycle_count      = 0;
    send_idle_pct    = 22;
    recv_stall_pct   = 22;
    recent           = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DIRECTED_ROWS[i])
      transfer_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].want);

    for (k = 0; k < RANDOM_ITEMS; k++) begin
      // Rotate idle patterns every 54 samples.
      case ((k / 54) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase

      // Long receiver hold-off while samples keep coming, so the input stalls.
      if (k == 10) hold_req = 1'b1;

      // Let everything drain once before continuing.
      if (k == 300) begin
        sample_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_medians.size() != 0);
      end

      // Mix of full-range values, small values, extremes and near-repeats.
      case ($urandom_range(7))
        3: s = $signed($urandom_range(40)) - 20;
        4: begin
          case ($urandom_range(3))
            0: s = 32'sh8000_0000;
            1: s = 32'sh7FFF_FFFF;
            2: s = '0;
            default: s = -1;
          endcase
        end
        5: s = recent;
        6: s = $signed($urandom) >>> $urandom_range(31);
        7: s = recent + $signed($urandom_range(4)) - 2;
        default: s = $urandom;
      endcase
      recent = s;
      transfer_sample(s, 1'b0, '0);
    end
    sample_ch.valid <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("running_median_tracker: match");
    else
      $display("running_median_tracker: mismatch");
    $finish;
  end

endmodule
